/* src/dsru_pkg.sv */
// ----------------------------------------------------------------------------
// dsru_pkg
// Shared widths, codes, reset values and types of the sector RLE unpacker.
// ----------------------------------------------------------------------------
package dsru_pkg;

    localparam int SECTOR_BYTES    = 256;
    localparam int MAX_SECTORS_DEF = 21;

    localparam int BYTE_W   = 8;
    localparam int SECT_W   = 5;
    localparam int TRACK_W  = 6;
    localparam int COUNT_W  = 9;
    localparam int ERR_W    = 3;
    localparam int LIMIT_W  = 6;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [TRACK_W-1:0] TRACK_RESET   = 6'd1;
    localparam logic [SECT_W-1:0]  SECTORS_RESET = 5'd21;

    // register indexes
    localparam logic REG_EXPECTED_TRACK   = 1'b0;
    localparam logic REG_SECTORS_IN_TRACK = 1'b1;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
    localparam logic [ERR_W-1:0] ERR_TRACK     = 3'd1;
    localparam logic [ERR_W-1:0] ERR_SECTOR    = 3'd2;
    localparam logic [ERR_W-1:0] ERR_METHOD    = 3'd3;
    localparam logic [ERR_W-1:0] ERR_DUPLICATE = 3'd4;

    // sector methods
    localparam logic [1:0] METH_STORED = 2'd0;
    localparam logic [1:0] METH_FILLED = 2'd1;
    localparam logic [1:0] METH_PACKED = 2'd2;
    localparam logic [1:0] METH_BAD    = 2'd3;

    typedef struct packed {
        logic [TRACK_W-1:0] expected_track;
        logic [SECT_W-1:0]  sectors_in_track;
    } t_cfg;

    typedef struct packed {
        logic [SECT_W-1:0]  sector_index;
        logic [BYTE_W-1:0]  byte_offset;
        logic [BYTE_W-1:0]  fill_value;
        logic [COUNT_W-1:0] repeat_count;
        logic               sector_done;
        logic               track_done;
        logic [ERR_W-1:0]   error_code;
    } t_result;

endpackage

/* src/dsru_if.sv */
// ----------------------------------------------------------------------------
// dsru_if
// Valid/ready channels: packed stream bytes in, write descriptors out.
// ----------------------------------------------------------------------------
interface dsru_byte_if;
    logic                       valid;
    logic                       ready;
    logic [dsru_pkg::BYTE_W-1:0] stream_byte;

    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface dsru_desc_if;
    logic                         valid;
    logic                         ready;
    logic [dsru_pkg::SECT_W-1:0]  sector_index;
    logic [dsru_pkg::BYTE_W-1:0]  byte_offset;
    logic [dsru_pkg::BYTE_W-1:0]  fill_value;
    logic [dsru_pkg::COUNT_W-1:0] repeat_count;
    logic                         sector_done;
    logic                         track_done;
    logic [dsru_pkg::ERR_W-1:0]   error_code;

    modport source (output valid, output sector_index, output byte_offset,
                    output fill_value, output repeat_count, output sector_done,
                    output track_done, output error_code, input ready);
    modport sink   (input valid, input sector_index, input byte_offset,
                    input fill_value, input repeat_count, input sector_done,
                    input track_done, input error_code, output ready);
endinterface

/* src/dsru_cfg.sv */
// ----------------------------------------------------------------------------
// dsru_cfg
// APB register file: expected track and sectors per track.
// ----------------------------------------------------------------------------
module dsru_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsru_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsru_pkg::PDATA_W-1:0]  pwdata,
    output logic [dsru_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output dsru_pkg::t_cfg                o_cfg
);
    import dsru_pkg::*;

    logic [TRACK_W-1:0] r_track;
    logic [SECT_W-1:0]  r_sectors;
    logic               wr_en;
    logic               reg_sel;

    assign reg_sel = paddr[2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track   <= TRACK_RESET;
            r_sectors <= SECTORS_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                REG_EXPECTED_TRACK:   r_track   <= pwdata[TRACK_W-1:0];
                REG_SECTORS_IN_TRACK: r_sectors <= pwdata[SECT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_EXPECTED_TRACK:   prdata = {{(PDATA_W-TRACK_W){1'b0}}, r_track};
            REG_SECTORS_IN_TRACK: prdata = {{(PDATA_W-SECT_W){1'b0}}, r_sectors};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.expected_track   = r_track;
    assign o_cfg.sectors_in_track = r_sectors;

endmodule

/* src/dsru_core.sv */
// ----------------------------------------------------------------------------
// dsru_core
// Per-byte decode of the packed track: header checks, method sequencing,
// run clipping and sector/track completion.
// ----------------------------------------------------------------------------
module dsru_core #(
    parameter int MAX_SECTORS = dsru_pkg::MAX_SECTORS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_take,
    input  logic [dsru_pkg::BYTE_W-1:0] i_byte,
    input  dsru_pkg::t_cfg              i_cfg,
    output logic                        o_res_valid,
    output dsru_pkg::t_result           o_res
);
    import dsru_pkg::*;

    localparam int IDX_W = (MAX_SECTORS > 1) ? $clog2(MAX_SECTORS) : 1;
    localparam logic [COUNT_W-1:0] FULL = COUNT_W'(SECTOR_BYTES);

    localparam logic [3:0] PH_TRACK  = 4'd0;
    localparam logic [3:0] PH_SECTOR = 4'd1;
    localparam logic [3:0] PH_STORED = 4'd2;
    localparam logic [3:0] PH_FILL   = 4'd3;
    localparam logic [3:0] PH_PLEN   = 4'd4;
    localparam logic [3:0] PH_PESC   = 4'd5;
    localparam logic [3:0] PH_TOKEN  = 4'd6;
    localparam logic [3:0] PH_COUNT  = 4'd7;
    localparam logic [3:0] PH_VALUE  = 4'd8;

    logic [3:0]             r_phase,  n_phase;
    logic [SECT_W-1:0]      r_cur,    n_cur;
    logic [COUNT_W-1:0]     r_wp,     n_wp;
    logic [COUNT_W-1:0]     r_tok,    n_tok;
    logic [BYTE_W-1:0]      r_plen,   n_plen;
    logic [BYTE_W-1:0]      r_esc,    n_esc;
    logic [BYTE_W-1:0]      r_run,    n_run;
    logic [1:0]             r_method, n_method;
    logic [MAX_SECTORS-1:0] r_seen,   n_seen;
    logic [SECT_W-1:0]      r_recv,   n_recv;
    logic [ERR_W-1:0]       r_err,    n_err;

    logic [LIMIT_W-1:0]     limit;
    logic [IDX_W-1:0]       sidx;
    logic [MAX_SECTORS-1:0] seen_bit;
    logic [COUNT_W-1:0]     tok_inc;

    logic                   wr_en;
    logic                   wr_fin;
    logic [BYTE_W-1:0]      wr_val;
    logic [COUNT_W-1:0]     wr_cnt;
    logic [COUNT_W-1:0]     room;
    logic [COUNT_W-1:0]     clip;
    logic [SECT_W-1:0]      recv_inc;

    assign limit = ({1'b0, i_cfg.sectors_in_track} < LIMIT_W'(MAX_SECTORS))
                 ? {1'b0, i_cfg.sectors_in_track} : LIMIT_W'(MAX_SECTORS);
    assign sidx    = i_byte[IDX_W-1:0];
    assign tok_inc = r_tok + COUNT_W'(1);

    always_comb begin
        seen_bit       = '0;
        seen_bit[sidx] = 1'b1;
    end

    always_comb begin
        n_phase     = r_phase;
        n_cur       = r_cur;
        n_wp        = r_wp;
        n_tok       = r_tok;
        n_plen      = r_plen;
        n_esc       = r_esc;
        n_run       = r_run;
        n_method    = r_method;
        n_seen      = r_seen;
        n_recv      = r_recv;
        n_err       = r_err;
        wr_en       = 1'b0;
        wr_fin      = 1'b0;
        wr_val      = '0;
        wr_cnt      = '0;
        room        = '0;
        clip        = '0;
        recv_inc    = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_take && r_err == ERR_NONE) begin
            case (r_phase)
                PH_TRACK: begin
                    if (i_byte[TRACK_W-1:0] != i_cfg.expected_track) begin
                        n_err             = ERR_TRACK;
                        n_cur             = '0;
                        o_res_valid       = 1'b1;
                        o_res.error_code  = ERR_TRACK;
                    end else begin
                        n_method = i_byte[7:6];
                        n_phase  = PH_SECTOR;
                    end
                end
                PH_SECTOR: begin
                    if (i_byte >= {2'b00, limit}) begin
                        n_err            = ERR_SECTOR;
                        n_cur            = '0;
                        o_res_valid      = 1'b1;
                        o_res.error_code = ERR_SECTOR;
                    end else if (r_method == METH_BAD) begin
                        n_err            = ERR_METHOD;
                        n_cur            = '0;
                        o_res_valid      = 1'b1;
                        o_res.error_code = ERR_METHOD;
                    end else if (r_seen[sidx]) begin
                        n_err            = ERR_DUPLICATE;
                        n_cur            = '0;
                        o_res_valid      = 1'b1;
                        o_res.error_code = ERR_DUPLICATE;
                    end else begin
                        n_seen = r_seen | seen_bit;
                        n_cur  = i_byte[SECT_W-1:0];
                        n_wp   = '0;
                        n_tok  = '0;
                        case (r_method)
                            METH_STORED: n_phase = PH_STORED;
                            METH_FILLED: n_phase = PH_FILL;
                            default:     n_phase = PH_PLEN;
                        endcase
                    end
                end
                PH_STORED: begin
                    wr_en  = 1'b1;
                    wr_val = i_byte;
                    wr_cnt = COUNT_W'(1);
                    wr_fin = (r_wp + COUNT_W'(1)) >= FULL;
                end
                PH_FILL: begin
                    wr_en  = 1'b1;
                    wr_val = i_byte;
                    wr_cnt = FULL;
                    wr_fin = 1'b1;
                end
                PH_PLEN: begin
                    n_plen  = i_byte;
                    n_phase = PH_PESC;
                end
                PH_PESC: begin
                    n_esc = i_byte;
                    n_tok = '0;
                    if (r_plen == '0) begin
                        wr_en  = 1'b1;
                        wr_fin = 1'b1;
                    end else begin
                        n_phase = PH_TOKEN;
                    end
                end
                PH_TOKEN: begin
                    if (i_byte == r_esc) begin
                        n_tok   = r_tok + COUNT_W'(3);
                        n_phase = PH_COUNT;
                    end else begin
                        n_tok  = tok_inc;
                        wr_en  = 1'b1;
                        wr_val = i_byte;
                        wr_cnt = COUNT_W'(1);
                        wr_fin = tok_inc >= {1'b0, r_plen};
                    end
                end
                PH_COUNT: begin
                    n_run   = i_byte;
                    n_phase = PH_VALUE;
                end
                PH_VALUE: begin
                    wr_en  = 1'b1;
                    wr_val = i_byte;
                    wr_cnt = {1'b0, r_run};
                    wr_fin = r_tok >= {1'b0, r_plen};
                    if (!wr_fin) begin
                        n_phase = PH_TOKEN;
                    end
                end
                default: begin
                    n_phase = PH_TRACK;
                end
            endcase
        end

        if (wr_en) begin
            room     = FULL - r_wp;
            clip     = (wr_cnt > room) ? room : wr_cnt;
            n_wp     = r_wp + clip;
            recv_inc = r_recv + SECT_W'(1);
            if (wr_fin) begin
                n_phase = PH_TRACK;
                n_recv  = recv_inc;
                if ({1'b0, recv_inc} >= limit) begin
                    o_res.track_done = 1'b1;
                    n_recv           = '0;
                    n_seen           = '0;
                end
            end
            if (clip != '0 || wr_fin) begin
                o_res_valid        = 1'b1;
                o_res.sector_index = r_cur;
                o_res.byte_offset  = (clip == '0) ? '0 : r_wp[BYTE_W-1:0];
                o_res.fill_value   = wr_val;
                o_res.repeat_count = clip;
                o_res.sector_done  = wr_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TRACK;
            r_cur    <= '0;
            r_wp     <= '0;
            r_tok    <= '0;
            r_plen   <= '0;
            r_esc    <= '0;
            r_run    <= '0;
            r_method <= '0;
            r_seen   <= '0;
            r_recv   <= '0;
            r_err    <= ERR_NONE;
        end else begin
            r_phase  <= n_phase;
            r_cur    <= n_cur;
            r_wp     <= n_wp;
            r_tok    <= n_tok;
            r_plen   <= n_plen;
            r_esc    <= n_esc;
            r_run    <= n_run;
            r_method <= n_method;
            r_seen   <= n_seen;
            r_recv   <= n_recv;
            r_err    <= n_err;
        end
    end

    a_err_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |=> (r_err == $past(r_err)))
        else $error("latched error changed");

    a_no_result_after_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ERR_NONE) |-> !o_res_valid)
        else $error("result produced while error latched");

    a_wp_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= FULL)
        else $error("write position beyond sector end");

    a_err_result_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.error_code != ERR_NONE) |->
        (o_res.repeat_count == '0 && !o_res.sector_done && !o_res.track_done))
        else $error("error result carries write or completion");

    a_track_implies_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.track_done) |-> o_res.sector_done)
        else $error("track done without sector done");

endmodule

/* src/disk_sector_rle_unpacker.sv */
// ----------------------------------------------------------------------------
// disk_sector_rle_unpacker
// Unpacks a run-length coded disk track into sector write descriptors.
// ----------------------------------------------------------------------------
// Usage:
//   i_stream carries one byte of the packed track per beat. o_desc carries one
//   write descriptor per beat: repeat_count copies of fill_value into sector
//   sector_index from byte_offset; repeat_count 0 is a status-only beat for
//   sector/track completion or an error. Bytes that produce nothing (headers,
//   lengths, escape tokens) are consumed silently.
//   The APB port holds expected_track at 0x0 and sectors_in_track at 0x4;
//   write them only while the block is idle.
//   Throughput is one byte per cycle while o_desc is not stalled: the
//   whole per-byte decode sits between the input register and the
//   descriptor register.
//   A stalled o_desc holds its beat; the input register then fills and
//   i_stream.ready drops until the descriptor is taken.
//   Synchronous reset returns the decoder to the track-header phase, clears
//   the sector map, counters and any latched error, and restores the
//   registers to track 1 and 21 sectors. After an error every byte is
//   dropped until reset.
// ----------------------------------------------------------------------------
module disk_sector_rle_unpacker #(
    parameter int MAX_SECTORS = dsru_pkg::MAX_SECTORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dsru_byte_if.sink                     i_stream,
    dsru_desc_if.source                   o_desc,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsru_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsru_pkg::PDATA_W-1:0]  pwdata,
    output logic [dsru_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import dsru_pkg::*;

    t_cfg              cfg;
    t_result           res;
    logic              res_valid;
    logic              take;
    logic              out_free;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;

    dsru_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    dsru_core #(
        .MAX_SECTORS (MAX_SECTORS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_byte      (r_in_byte),
        .i_cfg       (cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    assign out_free       = !r_out_valid || o_desc.ready;
    assign take           = r_in_valid && out_free;
    assign i_stream.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_stream.ready) begin
            r_in_valid <= i_stream.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_stream.ready && i_stream.valid) begin
            r_in_byte <= i_stream.stream_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res_valid;
        end else if (o_desc.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && res_valid) begin
            r_out <= res;
        end
    end

    assign o_desc.valid        = r_out_valid;
    assign o_desc.sector_index = r_out.sector_index;
    assign o_desc.byte_offset  = r_out.byte_offset;
    assign o_desc.fill_value   = r_out.fill_value;
    assign o_desc.repeat_count = r_out.repeat_count;
    assign o_desc.sector_done  = r_out.sector_done;
    assign o_desc.track_done   = r_out.track_done;
    assign o_desc.error_code   = r_out.error_code;

    a_take_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |-> (!r_out_valid || o_desc.ready))
        else $error("decode advanced over an untaken descriptor");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_desc.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled descriptor lost or changed");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_desc.ready) |-> !i_stream.ready)
        else $error("input accepted with both stages full");

endmodule

/* bench/dsru_checker.sv */
// ----------------------------------------------------------------------------
// dsru_checker
// Watches the byte, descriptor and APB channels of the sector RLE unpacker.
// Mirrors the decoder to predict each descriptor from each accepted byte.
// Compares every descriptor beat, oldest prediction first, and checks
// register read-back. Hands the mismatch count and the number of
// outstanding descriptors to the bench top.
// ----------------------------------------------------------------------------
module dsru_checker #(
    parameter int MAX_SECTORS = dsru_pkg::MAX_SECTORS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    dsru_byte_if                          stream_ch,
    dsru_desc_if                          desc_ch,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dsru_pkg::PADDR_W-1:0]  paddr,
    input  logic [dsru_pkg::PDATA_W-1:0]  pwdata,
    input  logic [dsru_pkg::PDATA_W-1:0]  prdata,
    input  logic                          pready,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import dsru_pkg::*;

    typedef enum logic [3:0] {
        ST_HEADER, ST_SECTOR, ST_STORED, ST_FILL, ST_PLEN,
        ST_PESC, ST_TOKEN, ST_COUNT, ST_VALUE
    } t_phase;

    t_cfg                   cfg;
    t_phase                 phase;
    logic [SECT_W-1:0]      cur_sector;
    logic [COUNT_W-1:0]     wr_pos;
    logic [COUNT_W-1:0]     tokens;
    logic [BYTE_W-1:0]      plen;
    logic [BYTE_W-1:0]      esc;
    logic [BYTE_W-1:0]      run_len;
    logic [1:0]             meth;
    logic [MAX_SECTORS-1:0] seen;
    logic [SECT_W-1:0]      done_sectors;
    logic [ERR_W-1:0]       err_latch;

    t_result                expected_desc[$];
    t_result                got;
    t_result                want;
    logic [PDATA_W-1:0]     want_rd;
    int                     mismatches;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatches++;
    endtask

    function automatic string desc_text(input t_result d);
        return $sformatf("sec %0d off %0d val 0x%02h cnt %0d sd %0b td %0b err %0d",
                         d.sector_index, d.byte_offset, d.fill_value, d.repeat_count,
                         d.sector_done, d.track_done, d.error_code);
    endfunction

    function automatic int sector_limit();
        return (int'(cfg.sectors_in_track) < MAX_SECTORS) ?
               int'(cfg.sectors_in_track) : MAX_SECTORS;
    endfunction

    task automatic raise_error(input logic [ERR_W-1:0] code);
        t_result r;
        r            = '0;
        r.error_code = code;
        err_latch    = code;
        cur_sector   = '0;
        expected_desc.push_back(r);
    endtask

    // clipped to the sector end; empty writes only show when they close the sector
    task automatic issue_write(input logic [BYTE_W-1:0] val, input int cnt,
                               input bit finishing);
        t_result r;
        int      room;
        int      off;
        bit      tdone;
        room  = SECTOR_BYTES - int'(wr_pos);
        off   = int'(wr_pos);
        tdone = 1'b0;
        if (cnt > room) cnt = room;
        wr_pos = wr_pos + COUNT_W'(cnt);
        if (finishing) begin
            phase        = ST_HEADER;
            done_sectors = done_sectors + 1'b1;
            if (int'(done_sectors) >= sector_limit()) begin
                tdone        = 1'b1;
                done_sectors = '0;
                seen         = '0;
            end
        end
        if (cnt != 0 || finishing) begin
            if (cnt == 0) off = 0;
            r.sector_index = cur_sector;
            r.byte_offset  = BYTE_W'(off);
            r.fill_value   = val;
            r.repeat_count = COUNT_W'(cnt);
            r.sector_done  = finishing;
            r.track_done   = tdone;
            r.error_code   = ERR_NONE;
            expected_desc.push_back(r);
        end
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        bit fin;
        if (err_latch != ERR_NONE) return;
        case (phase)
            ST_HEADER: begin
                if (b[TRACK_W-1:0] != cfg.expected_track) begin
                    raise_error(ERR_TRACK);
                end else begin
                    meth  = b[7:6];
                    phase = ST_SECTOR;
                end
            end
            ST_SECTOR: begin
                if (int'(b) >= sector_limit()) begin
                    raise_error(ERR_SECTOR);
                end else if (meth == METH_BAD) begin
                    raise_error(ERR_METHOD);
                end else if (seen[b]) begin
                    raise_error(ERR_DUPLICATE);
                end else begin
                    seen[b]    = 1'b1;
                    cur_sector = b[SECT_W-1:0];
                    wr_pos     = '0;
                    tokens     = '0;
                    phase      = (meth == METH_STORED) ? ST_STORED :
                                 (meth == METH_FILLED) ? ST_FILL : ST_PLEN;
                end
            end
            ST_STORED: issue_write(b, 1, int'(wr_pos) + 1 >= SECTOR_BYTES);
            ST_FILL:   issue_write(b, SECTOR_BYTES, 1'b1);
            ST_PLEN: begin
                plen  = b;
                phase = ST_PESC;
            end
            ST_PESC: begin
                esc    = b;
                tokens = '0;
                if (plen == '0) issue_write('0, 0, 1'b1);
                else phase = ST_TOKEN;
            end
            ST_TOKEN: begin
                if (b == esc) begin
                    tokens = tokens + COUNT_W'(3);
                    phase  = ST_COUNT;
                end else begin
                    tokens = tokens + 1'b1;
                    issue_write(b, 1, tokens >= plen);
                end
            end
            ST_COUNT: begin
                run_len = b;
                phase   = ST_VALUE;
            end
            ST_VALUE: begin
                fin = tokens >= plen;
                if (!fin) phase = ST_TOKEN;
                issue_write(b, int'(run_len), fin);
            end
            default: phase = ST_HEADER;
        endcase
    endtask

    assign o_fail_count = mismatches;

    initial begin
        mismatches = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.expected_track   = TRACK_RESET;
            cfg.sectors_in_track = SECTORS_RESET;
            phase                = ST_HEADER;
            cur_sector           = '0;
            wr_pos               = '0;
            tokens               = '0;
            plen                 = '0;
            esc                  = '0;
            run_len              = '0;
            meth                 = '0;
            seen                 = '0;
            done_sectors         = '0;
            err_latch            = ERR_NONE;
            expected_desc.delete();
        end else begin
            if (desc_ch.valid && desc_ch.ready) begin
                got = {desc_ch.sector_index, desc_ch.byte_offset, desc_ch.fill_value,
                       desc_ch.repeat_count, desc_ch.sector_done, desc_ch.track_done,
                       desc_ch.error_code};
                if (expected_desc.size() == 0) begin
                    report_mismatch({"unexpected beat ", desc_text(got)});
                end else begin
                    want = expected_desc.pop_front();
                    if (got !== want)
                        report_mismatch({"got ", desc_text(got), " want ", desc_text(want)});
                end
            end
            if (psel && penable && pready) begin
                if (pwrite) begin
                    if (paddr[PADDR_W-1:2] == REG_EXPECTED_TRACK)
                        cfg.expected_track = pwdata[TRACK_W-1:0];
                    else
                        cfg.sectors_in_track = pwdata[SECT_W-1:0];
                end else begin
                    want_rd = '0;
                    if (paddr[PADDR_W-1:2] == REG_EXPECTED_TRACK)
                        want_rd[TRACK_W-1:0] = cfg.expected_track;
                    else
                        want_rd[SECT_W-1:0] = cfg.sectors_in_track;
                    if (prdata !== want_rd)
                        report_mismatch($sformatf("read 0x%0h: got 0x%0h want 0x%0h",
                                                  paddr, prdata, want_rd));
                end
            end
            if (stream_ch.valid && stream_ch.ready) decode_byte(stream_ch.stream_byte);
        end
        o_pending = expected_desc.size();
    end

endmodule

/* bench/tb_disk_sector_rle_unpacker.sv */
// ----------------------------------------------------------------------------
// tb_disk_sector_rle_unpacker
// Bench top for the sector RLE unpacker.
// Sends a directed set of sectors (fill, empty packed, clipped runs), then
// random well-formed tracks of stored, filled and packed sectors under
// several track/sector settings, with random gaps on the byte side and
// random stalls on the descriptor side. Ends with one randomly chosen error
// and some ignored bytes. The checker predicts and compares; this module
// drives the stimulus and prints the verdict.
// ----------------------------------------------------------------------------
module tb_disk_sector_rle_unpacker;
    timeunit 1ns;
    timeprecision 1ps;

    import dsru_pkg::*;

    localparam int ITEMS       = 1650;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 1000000;

    localparam logic [BYTE_W-1:0] DIRECTED [30] = '{
        // filled, top sector
        {METH_FILLED, 6'd1}, 8'd20, 8'hFF,
        // packed, zero length
        {METH_PACKED, 6'd1}, 8'd0, 8'd0, 8'h55,
        // literals, empty run, run clipped at the sector end
        {METH_PACKED, 6'd1}, 8'd5, 8'd7, 8'hAA, 8'h00, 8'hFF,
        8'hAA, 8'd0, 8'h12, 8'hAA, 8'hFF, 8'h34,
        // sector already full when the last run lands
        {METH_PACKED, 6'd1}, 8'd9, 8'd6, 8'h00, 8'h00, 8'hFF, 8'h7E,
        8'h01, 8'h00, 8'd5, 8'h5A
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    int                 fail_count;
    int                 pending;

    dsru_byte_if byte_ch ();
    dsru_desc_if desc_ch ();

    logic [TRACK_W-1:0]         cur_track;
    logic [SECT_W-1:0]          cur_sectors;
    logic [MAX_SECTORS_DEF-1:0] used;
    bit                         calm;
    bit                         need_stored;
    int                         beats_sent;
    int                         sink_hold;
    int                         cycles;

    disk_sector_rle_unpacker u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_stream (byte_ch),
        .o_desc   (desc_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    dsru_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .stream_ch    (byte_ch),
        .desc_ch      (desc_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic int track_limit();
        return (int'(cur_sectors) < MAX_SECTORS_DEF) ? int'(cur_sectors) : MAX_SECTORS_DEF;
    endfunction

    always @(negedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold--;
            desc_ch.ready <= 1'b0;
        end else begin
            desc_ch.ready <= 1'b1;
            if ($urandom_range(0, 99) < 25) sink_hold = pick_gap();
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.stream_byte <= b;
        @(posedge i_clk);
        while (!byte_ch.ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // hold the byte side until every descriptor is out and the pipe is empty
    task automatic drain();
        @(negedge i_clk);
        byte_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic apb_access(input logic wr, input logic idx,
                              input logic [PDATA_W-1:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_config(input logic [TRACK_W-1:0] trk, input logic [SECT_W-1:0] secs);
        drain();
        apb_access(1'b1, REG_EXPECTED_TRACK, PDATA_W'(trk));
        apb_access(1'b1, REG_SECTORS_IN_TRACK, PDATA_W'(secs));
        apb_access(1'b0, REG_EXPECTED_TRACK, '0);
        apb_access(1'b0, REG_SECTORS_IN_TRACK, '0);
        cur_track   = trk;
        cur_sectors = secs;
    endtask

    task automatic send_random_sector(input int sec);
        logic [1:0]        meth;
        logic [BYTE_W-1:0] esc;
        logic [BYTE_W-1:0] lit;
        int                r;
        int                len;
        int                tokens;
        r = $urandom_range(0, 99);
        if (need_stored || r < 2) meth = METH_STORED;
        else if (r < 35) meth = METH_FILLED;
        else meth = METH_PACKED;
        need_stored = 1'b0;
        send_byte({meth, cur_track});
        send_byte(BYTE_W'(sec));
        case (meth)
            METH_STORED: repeat (SECTOR_BYTES) send_byte(BYTE_W'($urandom_range(0, 255)));
            METH_FILLED: send_byte(BYTE_W'($urandom_range(0, 255)));
            default: begin
                r = $urandom_range(0, 99);
                if (r < 5) len = 0;
                else if (r < 80) len = $urandom_range(1, 20);
                else if (r < 95) len = $urandom_range(21, 60);
                else len = $urandom_range(61, 255);
                esc = BYTE_W'($urandom_range(0, 255));
                send_byte(BYTE_W'(len));
                send_byte(esc);
                tokens = 0;
                while (tokens < len) begin
                    if ($urandom_range(0, 2) == 0) begin
                        r = $urandom_range(0, 99);
                        send_byte(esc);
                        if (r < 10) send_byte(8'd0);
                        else if (r < 30) send_byte(BYTE_W'($urandom_range(200, 255)));
                        else send_byte(BYTE_W'($urandom_range(1, 20)));
                        send_byte(BYTE_W'($urandom_range(0, 255)));
                        tokens += 3;
                    end else begin
                        lit = BYTE_W'($urandom_range(0, 255));
                        if (lit == esc) lit = ~esc;
                        send_byte(lit);
                        tokens++;
                    end
                end
            end
        endcase
    endtask

    // remaining sectors of the track in random order
    task automatic send_track();
        int pool[$];
        int s;
        int k;
        for (s = 0; s < track_limit(); s++)
            if (!used[s]) pool.push_back(s);
        while (pool.size() > 0) begin
            k = $urandom_range(0, pool.size() - 1);
            send_random_sector(pool[k]);
            pool.delete(k);
        end
        used = '0;
    endtask

    initial begin
        int iter;
        int s;
        i_rst_n             = 1'b0;
        byte_ch.valid       = 1'b0;
        byte_ch.stream_byte = '0;
        desc_ch.ready       = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        cur_track           = TRACK_RESET;
        cur_sectors         = SECTORS_RESET;
        used                = '0;
        calm                = 1'b0;
        need_stored         = 1'b1;
        beats_sent          = 0;
        sink_hold           = 0;
        cycles              = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i]) send_byte(DIRECTED[i]);
        used[20] = 1'b1;
        used[0]  = 1'b1;
        used[5]  = 1'b1;
        used[9]  = 1'b1;

        iter = 0;
        while (beats_sent < ITEMS) begin
            case (iter)
                0: ;
                1: set_config(6'd63, 5'd1);
                2: set_config(6'd1, 5'd21);
                3: set_config(6'b101010, 5'b01010);
                default: begin
                    s = $urandom_range(0, 99);
                    set_config(TRACK_W'($urandom_range(1, 63)),
                               (s < 15) ? 5'd21 : (s < 30) ? 5'd1 :
                               SECT_W'($urandom_range(1, 6)));
                end
            endcase
            calm = ($urandom_range(0, 4) == 0);
            send_track();
            iter++;
        end

        // one error per run, it latches until reset
        calm = 1'b0;
        drain();
        case ($urandom_range(0, 4))
            0: send_byte({2'($urandom_range(0, 3)), cur_track ^ TRACK_W'($urandom_range(1, 63))});
            1: begin
                send_byte({2'($urandom_range(0, 3)), cur_track});
                send_byte(BYTE_W'($urandom_range(track_limit(), 255)));
            end
            2: begin
                send_byte({METH_BAD, cur_track});
                send_byte(BYTE_W'($urandom_range(0, track_limit() - 1)));
            end
            3: begin
                if (track_limit() < 2) set_config(cur_track, 5'd21);
                s = $urandom_range(0, track_limit() - 1);
                send_byte({METH_FILLED, cur_track});
                send_byte(BYTE_W'(s));
                send_byte(BYTE_W'($urandom_range(0, 255)));
                send_byte({METH_PACKED, cur_track});
                send_byte(BYTE_W'(s));
            end
            default: begin
                set_config(cur_track, 5'd0);
                send_byte({METH_FILLED, cur_track});
                send_byte(BYTE_W'($urandom_range(0, 255)));
            end
        endcase
        repeat (12) send_byte(BYTE_W'($urandom_range(0, 255)));

        drain();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
